/* rtl/swdh_pkg.sv */
// SWD host transfer engine: shared types, codes and helper functions.
// No dependencies; every other file of the block uses this package.
package swdh_pkg;

    localparam int WORD_W  = 32;
    localparam int REQ_W   = 4;
    localparam int ACK_W   = 3;
    localparam int TRN_W   = 3;
    localparam int IDLE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // item command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // acknowledge codes
    localparam logic [ACK_W-1:0] ACK_OK    = 3'd1;
    localparam logic [ACK_W-1:0] ACK_WAIT  = 3'd2;
    localparam logic [ACK_W-1:0] ACK_FAULT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_PHASE = 2'd2;

    localparam logic [CNT_W-1:0] PKT_LEN   = 8'd8;
    localparam logic [CNT_W-1:0] ACK_LEN   = 8'd3;
    localparam logic [CNT_W-1:0] DATA_LEN  = 8'd32;
    localparam logic [CNT_W-1:0] PAR_LEN   = 8'd1;
    localparam logic [CNT_W-1:0] DUMMY_LEN = 8'd33;

    typedef enum logic [3:0] {
        PH_NONE   = 4'd0,
        PH_PKT    = 4'd1,
        PH_TRN1   = 4'd2,
        PH_ACK    = 4'd3,
        PH_RDATA  = 4'd4,
        PH_RPAR   = 4'd5,
        PH_RTRN   = 4'd6,
        PH_WTRN   = 4'd7,
        PH_WDATA  = 4'd8,
        PH_WPAR   = 4'd9,
        PH_IDLE   = 4'd10,
        PH_DREAD  = 4'd11,
        PH_TRNEND = 4'd12,
        PH_TRNDW  = 4'd13,
        PH_DWRITE = 4'd14,
        PH_PROTO  = 4'd15
    } t_phase;

    typedef struct packed {
        logic [TRN_W-1:0]  turnaround_cycles;
        logic [IDLE_W-1:0] idle_cycle_count;
        logic              data_phase_on_wait;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [REQ_W-1:0]  request_bits;
        logic [WORD_W-1:0] write_word;
        logic              line_in;
    } t_in_item;

    typedef struct packed {
        logic              line_out;
        logic              line_drive;
        logic              clock_pulse;
        logic              transfer_done;
        logic [ACK_W-1:0]  ack_code;
        logic              parity_fail;
        logic [WORD_W-1:0] read_word;
    } t_out_item;

    // a programmed turnaround of zero is replaced by the smallest nonzero setting
    function automatic logic [TRN_W-1:0] ta_len(input logic [TRN_W-1:0] tc);
        return (tc == '0) ? TRN_W'(1) : tc;
    endfunction

    function automatic logic [CNT_W-1:0] phase_len(input t_phase p, input t_cfg cfg);
        logic [CNT_W-1:0] ta;
        ta = CNT_W'(ta_len(cfg.turnaround_cycles));
        case (p)
            PH_PKT:                    return PKT_LEN;
            PH_ACK:                    return ACK_LEN;
            PH_RDATA, PH_WDATA:        return DATA_LEN;
            PH_RPAR, PH_WPAR:          return PAR_LEN;
            PH_IDLE:                   return cfg.idle_cycle_count;
            PH_DREAD, PH_DWRITE:       return DUMMY_LEN;
            PH_PROTO:                  return ta + DUMMY_LEN;
            PH_TRN1, PH_RTRN, PH_WTRN,
            PH_TRNEND, PH_TRNDW:       return ta;
            default:                   return '0;
        endcase
    endfunction

endpackage

/* rtl/swdh_if.sv */
// SWD host transfer engine: channel interfaces (item in, result out, config write).
// Depends on swdh_pkg for widths.
interface swdh_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [swdh_pkg::REQ_W-1:0]  request_bits;
    logic [swdh_pkg::WORD_W-1:0] write_word;
    logic                       line_in;

    modport source (output valid, cmd, request_bits, write_word, line_in, input ready);
    modport sink   (input valid, cmd, request_bits, write_word, line_in, output ready);
endinterface

interface swdh_out_if;
    logic                       valid;
    logic                       ready;
    logic                       line_out;
    logic                       line_drive;
    logic                       clock_pulse;
    logic                       transfer_done;
    logic [swdh_pkg::ACK_W-1:0]  ack_code;
    logic                       parity_fail;
    logic [swdh_pkg::WORD_W-1:0] read_word;

    modport source (output valid, line_out, line_drive, clock_pulse, transfer_done,
                    ack_code, parity_fail, read_word, input ready);
    modport sink   (input valid, line_out, line_drive, clock_pulse, transfer_done,
                    ack_code, parity_fail, read_word, output ready);
endinterface

interface swdh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [swdh_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [swdh_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

/* rtl/swdh_seq.sv */
// SWD host transfer engine: transfer sequencer (phase, bit counter, shift and parity).
// Depends on swdh_pkg. Updates state on each accepted item and returns its result.
module swdh_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  swdh_pkg::t_in_item  i_item,
    input  swdh_pkg::t_cfg      i_cfg,
    output swdh_pkg::t_out_item o_res
);
    import swdh_pkg::*;

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [WORD_W-1:0] r_shift, n_shift;
    logic [REQ_W-1:0]  r_req,   n_req;
    logic [ACK_W-1:0]  r_ack,   n_ack;
    logic              r_par,   n_par;

    logic              w_start, w_tick, w_last, w_rd, w_pkt_par, w_done;
    logic [7:0]        w_pkt;
    logic [2:0]        w_pkt_idx;
    logic [1:0]        w_ack_sh;
    logic [CNT_W-1:0]  w_dec;
    logic              w_lout, w_drive;
    t_phase            w_nxt;

    assign w_start   = (i_item.cmd == CMD_START);
    assign w_tick    = (i_item.cmd == CMD_TICK) && (r_phase != PH_NONE);
    assign w_dec     = (r_count != '0) ? r_count - CNT_W'(1) : '0;
    assign w_last    = w_tick && (w_dec == '0);
    assign w_rd      = r_req[1];
    assign w_pkt_par = ^r_req;
    assign w_pkt     = {1'b1, 1'b0, w_pkt_par, r_req, 1'b1};
    // packet bit index runs 0..7 as the counter runs 8..1
    assign w_pkt_idx = 3'd0 - r_count[2:0];
    assign w_ack_sh  = 2'd3 - r_count[1:0];

    // line and datapath for this cycle
    always_comb begin
        n_shift = r_shift;
        n_req   = r_req;
        n_ack   = r_ack;
        n_par   = r_par;
        w_lout  = 1'b0;
        w_drive = 1'b1;
        if (w_start) begin
            n_req   = i_item.request_bits;
            n_shift = i_item.write_word;
            n_ack   = '0;
            n_par   = 1'b0;
        end else if (w_tick) begin
            w_drive = 1'b0;
            case (r_phase)
                PH_PKT: begin
                    w_lout  = w_pkt[w_pkt_idx];
                    w_drive = 1'b1;
                end
                PH_ACK: begin
                    n_ack = r_ack | (ACK_W'(i_item.line_in) << w_ack_sh);
                end
                PH_RDATA: begin
                    n_shift = {i_item.line_in, r_shift[WORD_W-1:1]};
                    n_par   = r_par ^ i_item.line_in;
                end
                PH_RPAR: begin
                    n_par = r_par ^ i_item.line_in;
                end
                PH_WTRN: begin
                    // write parity starts fresh at the data phase
                    if (w_last) begin
                        n_par = 1'b0;
                    end
                end
                PH_WDATA: begin
                    w_lout  = r_shift[0];
                    n_par   = r_par ^ r_shift[0];
                    n_shift = {1'b0, r_shift[WORD_W-1:1]};
                    w_drive = 1'b1;
                end
                PH_WPAR: begin
                    w_lout  = r_par;
                    w_drive = 1'b1;
                end
                PH_IDLE, PH_DWRITE: begin
                    w_drive = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // phase successor, using the acknowledge as updated this cycle
    always_comb begin
        case (r_phase)
            PH_PKT:  w_nxt = PH_TRN1;
            PH_TRN1: w_nxt = PH_ACK;
            PH_ACK: begin
                if (n_ack == ACK_OK) begin
                    w_nxt = w_rd ? PH_RDATA : PH_WTRN;
                end else if (n_ack == ACK_WAIT || n_ack == ACK_FAULT) begin
                    if (!i_cfg.data_phase_on_wait) begin
                        w_nxt = PH_TRNEND;
                    end else begin
                        w_nxt = w_rd ? PH_DREAD : PH_TRNDW;
                    end
                end else begin
                    w_nxt = PH_PROTO;
                end
            end
            PH_RDATA: w_nxt = PH_RPAR;
            PH_RPAR:  w_nxt = PH_RTRN;
            PH_RTRN:  w_nxt = PH_IDLE;
            PH_WTRN:  w_nxt = PH_WDATA;
            PH_WDATA: w_nxt = PH_WPAR;
            PH_WPAR:  w_nxt = PH_IDLE;
            PH_DREAD: w_nxt = PH_TRNEND;
            PH_TRNDW: w_nxt = PH_DWRITE;
            default:  w_nxt = PH_NONE;
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (w_start) begin
            n_phase = PH_PKT;
            n_count = PKT_LEN;
        end else if (w_tick) begin
            n_count = w_dec;
            if (w_last) begin
                // an empty idle phase is skipped
                if (w_nxt == PH_IDLE && i_cfg.idle_cycle_count == '0) begin
                    n_phase = PH_NONE;
                end else begin
                    n_phase = w_nxt;
                end
                n_count = phase_len(n_phase, i_cfg);
            end
        end
    end

    assign w_done = w_tick && (n_phase == PH_NONE);

    always_comb begin
        o_res.line_out      = w_lout;
        o_res.line_drive    = w_drive;
        o_res.clock_pulse   = w_tick;
        o_res.transfer_done = w_done;
        o_res.ack_code      = n_ack;
        o_res.parity_fail   = 1'b0;
        o_res.read_word     = '0;
        if (w_done && n_ack == ACK_OK && w_rd) begin
            o_res.parity_fail = n_par;
            o_res.read_word   = n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_count <= '0;
            r_shift <= '0;
            r_req   <= '0;
            r_ack   <= '0;
            r_par   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            r_req   <= n_req;
            r_ack   <= n_ack;
            r_par   <= n_par;
        end
    end

`ifndef NO_ASSERTIONS
    // outside a transfer the counter is idle
    a_none_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NONE) |-> (r_count == '0))
        else $error("counter nonzero with no transfer");
    // every active phase has a nonzero count left
    a_act_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_NONE) |-> (r_count != '0))
        else $error("active phase with empty counter");
    // a start item always lands in the packet phase
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_start) |=> (r_phase == PH_PKT && r_count == PKT_LEN && r_ack == '0))
        else $error("start did not load packet phase");
`endif
endmodule

/* rtl/swd_host_transfer_engine.sv */
// SWD host transfer engine, top level: channels, configuration registers, result register.
// Depends on swdh_pkg, swdh_if and swdh_seq.
//
// One item per clock unless the output stalls: each tick item is an SWCLK cycle, and its
// result is computed in the accept cycle by the sequencer and held in a single result
// register, which is refilled in the same cycle it is taken, so the input is ready whenever
// that register is empty or being drained. There is no reset sweep. Configuration writes
// are always accepted; a changed setting applies to each phase that begins after the write.
module swd_host_transfer_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swdh_in_if.sink     i_in,
    swdh_out_if.source  o_out,
    swdh_cfg_if.sink    i_cfg
);
    import swdh_pkg::*;

    t_cfg       r_cfg;
    t_in_item   w_item;
    t_out_item  w_res, r_res;
    logic       r_out_valid;
    logic       w_accept;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turnaround_cycles  <= TRN_W'(1);
            r_cfg.idle_cycle_count   <= '0;
            r_cfg.data_phase_on_wait <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.wr_index)
                CFG_TURNAROUND: r_cfg.turnaround_cycles  <= i_cfg.wr_data[TRN_W-1:0];
                CFG_IDLE_COUNT: r_cfg.idle_cycle_count   <= i_cfg.wr_data[IDLE_W-1:0];
                CFG_DATA_PHASE: r_cfg.data_phase_on_wait <= i_cfg.wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_item.cmd          = i_in.cmd;
    assign w_item.request_bits = i_in.request_bits;
    assign w_item.write_word   = i_in.write_word;
    assign w_item.line_in      = i_in.line_in;

    swdh_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.line_out      = r_res.line_out;
    assign o_out.line_drive    = r_res.line_drive;
    assign o_out.clock_pulse   = r_res.clock_pulse;
    assign o_out.transfer_done = r_res.transfer_done;
    assign o_out.ack_code      = r_res.ack_code;
    assign o_out.parity_fail   = r_res.parity_fail;
    assign o_out.read_word     = r_res.read_word;

`ifndef NO_ASSERTIONS
    // an accepted item always leaves a result behind
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");
    // a released line never carries a high level
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.line_drive) |-> !r_res.line_out)
        else $error("line high while released");
    // done only on a clocked cycle
    a_done_clk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.transfer_done) |-> r_res.clock_pulse)
        else $error("done without a clock cycle");
    // read data only shows at the end of an OK transfer
    a_rword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.read_word != '0 || r_res.parity_fail))
        |-> (r_res.transfer_done && r_res.ack_code == ACK_OK))
        else $error("read data outside an OK done");
`endif
endmodule
